FILE: rtl/core/cdsb_pkg.sv
// Shared types, constants and helper functions of the clock and date setting buttons unit.
package cdsb_pkg;

  localparam int unsigned HistoryBitsDefault = 4;

  // Field widths of one input item and one result item.
  localparam int unsigned HoursW   = 6;
  localparam int unsigned MinutesW = 7;
  localparam int unsigned YearW    = 7;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned ModeW    = 3;

  // Wrap and clamp limits of the adjustable fields.
  localparam logic [5:0] HoursMax   = 6'd23;
  localparam logic [5:0] HoursMod   = 6'd24;
  localparam logic [6:0] MinutesMax = 7'd59;
  localparam logic [6:0] MinutesMod = 7'd60;
  localparam logic [6:0] YearMax    = 7'd99;
  localparam logic [6:0] YearMod    = 7'd100;
  localparam logic [3:0] MonthMax   = 4'd12;
  localparam logic [3:0] MonthMod   = 4'd13;
  localparam logic [2:0] WeekdayMax = 3'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL  = 3'd0,
    MODE_HOURS   = 3'd1,
    MODE_MINUTES = 3'd2,
    MODE_YEAR    = 3'd3,
    MODE_MONTH   = 3'd4,
    MODE_DAY     = 3'd5,
    MODE_WEEKDAY = 3'd6
  } mode_e;

  // Advances the setting mode, wrapping from weekday back to normal.
  function automatic mode_e mode_next(input mode_e m);
    mode_e r;
    if (m == MODE_WEEKDAY) begin
      r = MODE_NORMAL;
    end else begin
      r = mode_e'(m + 3'd1);
    end
    return r;
  endfunction

  // Converts a binary value below 100 to two BCD digits; tens come from a
  // multiplication by 103/1024, which is exact in that range.
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rest;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    rest = v - 7'(7'(tens) * 7'd10);
    return {tens, rest[3:0]};
  endfunction

endpackage

FILE: rtl/core/cdsb_if.sv
// Channel interfaces of the clock and date setting buttons unit: button tick in, result out.
interface cdsb_in_if;
  import cdsb_pkg::*;

  logic                valid;
  logic                ready;
  logic                up_level;
  logic                down_level;
  logic                mode_level;
  logic                remote_mode;
  logic                remote_up;
  logic                remote_down;
  logic [HoursW-1:0]   cur_hours_bcd;
  logic [MinutesW-1:0] cur_minutes_bcd;
  logic [YearW-1:0]    cur_year;
  logic [MonthW-1:0]   cur_month;
  logic [DayW-1:0]     cur_day;
  logic [WeekdayW-1:0] cur_weekday;

  modport source (
    output valid, up_level, down_level, mode_level, remote_mode, remote_up, remote_down,
           cur_hours_bcd, cur_minutes_bcd, cur_year, cur_month, cur_day, cur_weekday,
    input  ready
  );

  modport sink (
    input  valid, up_level, down_level, mode_level, remote_mode, remote_up, remote_down,
           cur_hours_bcd, cur_minutes_bcd, cur_year, cur_month, cur_day, cur_weekday,
    output ready
  );
endinterface

interface cdsb_out_if;
  import cdsb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode_now;
  logic                set_time;
  logic                set_date;
  logic [HoursW-1:0]   new_hours_bcd;
  logic [MinutesW-1:0] new_minutes_bcd;
  logic [YearW-1:0]    new_year;
  logic [MonthW-1:0]   new_month;
  logic [DayW-1:0]     new_day;
  logic [WeekdayW-1:0] new_weekday;
  logic                show_date;
  logic                led_state;

  modport source (
    output valid, mode_now, set_time, set_date, new_hours_bcd, new_minutes_bcd, new_year,
           new_month, new_day, new_weekday, show_date, led_state,
    input  ready
  );

  modport sink (
    input  valid, mode_now, set_time, set_date, new_hours_bcd, new_minutes_bcd, new_year,
           new_month, new_day, new_weekday, show_date, led_state,
    output ready
  );
endinterface

FILE: rtl/core/clock_date_setting_buttons_unit.sv
// Top level of the clock and date setting buttons unit: press detection, mode and field adjust.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register advances whenever the result register
// is empty or being emptied, so a waiting result blocks new items only once the input
// register holds an item as well.
// Reset: rst_ni clears the mode, the button histories, the pending remote clicks, the LED
// and both valid flags; the block takes items from the first cycle after reset.
module clock_date_setting_buttons_unit #(
  parameter int unsigned HISTORY_BITS = cdsb_pkg::HistoryBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cdsb_in_if.sink        in_i,
  cdsb_out_if.source     out_o
);
  import cdsb_pkg::*;

  localparam logic [HISTORY_BITS-1:0] PressPattern = HISTORY_BITS'(1);

  // Input register.
  logic                s1_valid_q;
  logic                up_lvl_q, down_lvl_q, mode_lvl_q;
  logic                rem_mode_q, rem_up_q, rem_down_q;
  logic [HoursW-1:0]   hh_q;
  logic [MinutesW-1:0] mm_q;
  logic [YearW-1:0]    yy_q;
  logic [MonthW-1:0]   mo_q;
  logic [DayW-1:0]     dd_q;
  logic [WeekdayW-1:0] wd_q;

  // Block state.
  mode_e                   mode_q, mode_d;
  logic [HISTORY_BITS-1:0] up_hist_q, up_hist_d;
  logic [HISTORY_BITS-1:0] down_hist_q, down_hist_d;
  logic [HISTORY_BITS-1:0] mode_hist_q, mode_hist_d;
  logic                    pend_up_q, pend_up_d;
  logic                    pend_down_q, pend_down_d;
  logic                    led_q, led_d;

  // Result register.
  logic                out_valid_q;
  mode_e               r_mode_q;
  logic                r_set_time_q, r_set_date_q, r_show_q, r_led_q;
  logic [HoursW-1:0]   r_hh_q, r_hh_d;
  logic [MinutesW-1:0] r_mm_q, r_mm_d;
  logic [YearW-1:0]    r_yy_q, r_yy_d;
  logic [MonthW-1:0]   r_mo_q, r_mo_d;
  logic [DayW-1:0]     r_dd_q, r_dd_d;
  logic [WeekdayW-1:0] r_wd_q, r_wd_d;
  logic                set_time_d, set_date_d, show_d;

  logic advance;
  logic in_fire;

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      up_lvl_q   <= in_i.up_level;
      down_lvl_q <= in_i.down_level;
      mode_lvl_q <= in_i.mode_level;
      rem_mode_q <= in_i.remote_mode;
      rem_up_q   <= in_i.remote_up;
      rem_down_q <= in_i.remote_down;
      hh_q       <= in_i.cur_hours_bcd;
      mm_q       <= in_i.cur_minutes_bcd;
      yy_q       <= in_i.cur_year;
      mo_q       <= in_i.cur_month;
      dd_q       <= in_i.cur_day;
      wd_q       <= in_i.cur_weekday;
    end
  end

  // Press detection and mode update.
  logic                    pend_up, pend_down;
  mode_e                   mode_a;
  logic [HISTORY_BITS-1:0] up_sh, down_sh, mode_sh;
  logic                    up_fire, down_fire, mode_press, adj_fire;

  always_comb begin
    pend_up   = pend_up_q || rem_up_q;
    pend_down = pend_down_q || rem_down_q;
    mode_a    = rem_mode_q ? mode_next(mode_q) : mode_q;

    up_sh   = {up_hist_q[HISTORY_BITS-2:0], up_lvl_q};
    down_sh = {down_hist_q[HISTORY_BITS-2:0], down_lvl_q};
    mode_sh = {mode_hist_q[HISTORY_BITS-2:0], mode_lvl_q};

    // A history shifts only when its test is reached: up, then down, then mode.
    up_fire    = pend_up || (up_sh == PressPattern);
    down_fire  = !up_fire && (pend_down || (down_sh == PressPattern));
    mode_press = !up_fire && !down_fire && (mode_sh == PressPattern);
    adj_fire   = up_fire || down_fire;

    up_hist_d   = pend_up ? up_hist_q : up_sh;
    down_hist_d = (!up_fire && !pend_down) ? down_sh : down_hist_q;
    mode_hist_d = (!up_fire && !down_fire) ? mode_sh : mode_hist_q;

    pend_up_d   = up_fire ? 1'b0 : pend_up;
    pend_down_d = down_fire ? 1'b0 : pend_down;

    mode_d = mode_press ? mode_next(mode_a) : mode_a;
    show_d = mode_press && (mode_d == MODE_NORMAL || mode_d == MODE_WEEKDAY);
    led_d  = led_q ^ mode_press;

    set_date_d = adj_fire && (mode_a == MODE_YEAR || mode_a == MODE_MONTH ||
                              mode_a == MODE_DAY || mode_a == MODE_WEEKDAY);
    set_time_d = adj_fire && (mode_a == MODE_HOURS || mode_a == MODE_MINUTES);
  end

  // Field adjust; BCD digits above nine decode as their nibble value.
  logic [5:0] hv, hv_inc, hv_new;
  logic [6:0] mv, mv_inc, mv_new;
  logic [7:0] yv_inc;
  logic [4:0] mo_inc;
  logic [7:0] h_bcd, m_bcd;

  always_comb begin
    hv     = 6'(6'(hh_q[5:4]) * 6'd10) + 6'(hh_q[3:0]);
    mv     = 7'(7'(mm_q[6:4]) * 7'd10) + 7'(mm_q[3:0]);
    hv_inc = hv + 6'd1;
    mv_inc = mv + 7'd1;
    yv_inc = 8'(yy_q) + 8'd1;
    mo_inc = 5'(mo_q) + 5'd1;

    if (up_fire) begin
      hv_new = (hv_inc >= HoursMod) ? hv_inc - HoursMod : hv_inc;
      mv_new = (mv_inc >= MinutesMod) ? mv_inc - MinutesMod : mv_inc;
    end else begin
      hv_new = (hv == 6'd0 || hv > HoursMax) ? HoursMax : hv - 6'd1;
      mv_new = (mv == 7'd0 || mv > MinutesMax) ? MinutesMax : mv - 7'd1;
    end
    h_bcd = bin_to_bcd(7'(hv_new));
    m_bcd = bin_to_bcd(mv_new);

    r_hh_d = hh_q;
    r_mm_d = mm_q;
    r_yy_d = yy_q;
    r_mo_d = mo_q;
    r_dd_d = dd_q;
    r_wd_d = wd_q;

    if (adj_fire) begin
      case (mode_a)
        MODE_HOURS: begin
          r_hh_d = h_bcd[5:0];
        end
        MODE_MINUTES: begin
          r_mm_d = m_bcd[6:0];
        end
        MODE_YEAR: begin
          if (up_fire) begin
            r_yy_d = (yv_inc >= 8'(YearMod)) ? 7'(yv_inc - 8'(YearMod)) : yv_inc[6:0];
          end else if (yy_q == 7'd0) begin
            r_yy_d = 7'd0;
          end else begin
            r_yy_d = (yy_q > YearMax) ? YearMax : yy_q - 7'd1;
          end
        end
        MODE_MONTH: begin
          if (up_fire) begin
            if (mo_inc == 5'(MonthMod)) begin
              r_mo_d = 4'd1;
            end else if (mo_inc > 5'(MonthMod)) begin
              r_mo_d = 4'(mo_inc - 5'(MonthMod));
            end else begin
              r_mo_d = mo_inc[3:0];
            end
          end else begin
            r_mo_d = (mo_q <= 4'd1 || mo_q > MonthMax) ? MonthMax : mo_q - 4'd1;
          end
        end
        MODE_DAY: begin
          if (up_fire) begin
            r_dd_d = (dd_q == 5'd31) ? 5'd1 : dd_q + 5'd1;
          end else begin
            r_dd_d = (dd_q > 5'd1) ? dd_q - 5'd1 : 5'd1;
          end
        end
        MODE_WEEKDAY: begin
          if (up_fire) begin
            r_wd_d = (wd_q == WeekdayMax) ? 3'd1 : wd_q + 3'd1;
          end else begin
            r_wd_d = (wd_q <= 3'd1) ? WeekdayMax : wd_q - 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      up_hist_q   <= '0;
      down_hist_q <= '0;
      mode_hist_q <= '0;
      pend_up_q   <= 1'b0;
      pend_down_q <= 1'b0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q      <= mode_d;
        up_hist_q   <= up_hist_d;
        down_hist_q <= down_hist_d;
        mode_hist_q <= mode_hist_d;
        pend_up_q   <= pend_up_d;
        pend_down_q <= pend_down_d;
        led_q       <= led_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_mode_q     <= mode_d;
      r_set_time_q <= set_time_d;
      r_set_date_q <= set_date_d;
      r_show_q     <= show_d;
      r_led_q      <= led_d;
      r_hh_q       <= r_hh_d;
      r_mm_q       <= r_mm_d;
      r_yy_q       <= r_yy_d;
      r_mo_q       <= r_mo_d;
      r_dd_q       <= r_dd_d;
      r_wd_q       <= r_wd_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.mode_now        = r_mode_q;
  assign out_o.set_time        = r_set_time_q;
  assign out_o.set_date        = r_set_date_q;
  assign out_o.new_hours_bcd   = r_hh_q;
  assign out_o.new_minutes_bcd = r_mm_q;
  assign out_o.new_year        = r_yy_q;
  assign out_o.new_month       = r_mo_q;
  assign out_o.new_day         = r_dd_q;
  assign out_o.new_weekday     = r_wd_q;
  assign out_o.show_date       = r_show_q;
  assign out_o.led_state       = r_led_q;

endmodule
